// ===== rtl/lrs_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, codes and types of the link reconnect supervisor
package lrs_pkg;

  localparam int NETWORKS   = 8;
  localparam int CONSUMERS  = 4;

  localparam int OP_W       = 3;
  localparam int CONS_W     = 2;
  localparam int MS_W       = 20;
  localparam int CNT_W      = 32;
  localparam int NCOUNT_W   = 4;
  localparam int NET_W      = 3;
  localparam int MODE_W     = 3;
  localparam int ACT_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // remainder unit: dividend is next_network or next_network + 1
  localparam int DIV_W      = NET_W + 1;
  localparam int STEP_W     = $clog2(DIV_W);
  localparam int TRIAL_W    = NCOUNT_W + DIV_W - 1;

  localparam logic [MS_W-1:0] INIT_BACKOFF_RST = MS_W'(1000);
  localparam logic [MS_W-1:0] MAX_BACKOFF_RST  = MS_W'(60000);

  typedef enum logic [OP_W-1:0] {
    OP_REQUEST   = 3'd0,
    OP_RELEASE   = 3'd1,
    OP_RADIO_UP  = 3'd2,
    OP_LINK_LOST = 3'd3,
    OP_ADDR_OK   = 3'd4
  } op_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF        = 3'd0,
    MODE_CONNECTING = 3'd1,
    MODE_CONNECTED  = 3'd2,
    MODE_BACKOFF    = 3'd3,
    MODE_NO_CONFIG  = 3'd4
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INIT_BACKOFF = 2'd0,
    CFG_MAX_BACKOFF  = 2'd1,
    CFG_NET_COUNT    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    mode_t              link_state;
    logic               radio_start;
    logic               radio_stop;
    logic               connect_now;
    logic [NET_W-1:0]   network_index;
    logic [MS_W-1:0]    wait_ms;
    logic               address_held;
    logic [ACT_W-1:0]   active_consumers;
    logic [CNT_W-1:0]   attempt_count;
    logic [CNT_W-1:0]   failure_count;
    logic [CNT_W-1:0]   disconnect_count;
    logic [MS_W-1:0]    backoff_level_ms;
  } result_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_busy;
  } dp_status_t;

  function automatic logic [ACT_W-1:0] count_requests(input logic [CONSUMERS-1:0] bits);
    logic [ACT_W-1:0] n;
    n = '0;
    for (int i = 0; i < CONSUMERS; i++) begin
      n = n + ACT_W'(bits[i]);
    end
    return n;
  endfunction

endpackage

// ===== rtl/lrs_if.sv =====
`timescale 1ns / 1ps
// event and result channel interfaces
interface lrs_event_if import lrs_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [CONS_W-1:0] consumer;

  modport source (output valid, output op, output consumer, input ready);
  modport sink   (input valid, input op, input consumer, output ready);
endinterface

interface lrs_result_if import lrs_pkg::*;;
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  link_state;
  logic               radio_start;
  logic               radio_stop;
  logic               connect_now;
  logic [NET_W-1:0]   network_index;
  logic [MS_W-1:0]    wait_ms;
  logic               address_held;
  logic [ACT_W-1:0]   active_consumers;
  logic [CNT_W-1:0]   attempt_count;
  logic [CNT_W-1:0]   failure_count;
  logic [CNT_W-1:0]   disconnect_count;
  logic [MS_W-1:0]    backoff_level_ms;

  modport source (
    output valid, link_state, radio_start, radio_stop, connect_now, network_index,
    output wait_ms, address_held, active_consumers, attempt_count, failure_count,
    output disconnect_count, backoff_level_ms,
    input  ready
  );
  modport sink (
    input  valid, link_state, radio_start, radio_stop, connect_now, network_index,
    input  wait_ms, address_held, active_consumers, attempt_count, failure_count,
    input  disconnect_count, backoff_level_ms,
    output ready
  );
endinterface

// ===== rtl/lrs_ctrl.sv =====
`timescale 1ns / 1ps
// sequencing state machine: accept, remainder steps, commit
module lrs_ctrl import lrs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       evt_valid,
  output logic       evt_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DIV    = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    evt_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        evt_ready = 1'b1;
        if (evt_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (status.div_last) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        // hold until the output register can take the result
        if (!status.out_busy) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/lrs_datapath.sv =====
`timescale 1ns / 1ps
// config registers, link state, remainder unit and result register
module lrs_datapath import lrs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [OP_W-1:0]       op,
  input  logic [CONS_W-1:0]     consumer,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            status,
  output logic                  res_valid,
  input  logic                  res_ready,
  output result_t               res_data
);

  logic [MS_W-1:0]      initial_backoff;
  logic [MS_W-1:0]      max_backoff;
  logic [NCOUNT_W-1:0]  network_count;

  logic [CONSUMERS-1:0] request_bits, request_bits_next;
  mode_t                link_mode, link_mode_next;
  logic                 has_address, has_address_next;
  logic [MS_W-1:0]      backoff_now, backoff_now_next;
  logic [NET_W-1:0]     next_network, next_network_next;
  logic [CNT_W-1:0]     attempts_seen, attempts_seen_next;
  logic [CNT_W-1:0]     failures_seen, failures_seen_next;
  logic [CNT_W-1:0]     disconnects_seen, disconnects_seen_next;

  logic [OP_W-1:0]      op_q;
  logic [CONS_W-1:0]    consumer_q;
  logic [DIV_W-1:0]     rem;
  logic [STEP_W-1:0]    step;

  logic [NCOUNT_W-1:0]  nets;
  logic [DIV_W-1:0]     dividend;
  logic [TRIAL_W-1:0]   trial;
  logic [MS_W:0]        doubled;
  logic [CONSUMERS-1:0] bit_mask;
  logic [ACT_W-1:0]     held;
  logic                 do_attempt;
  result_t              result;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_backoff <= INIT_BACKOFF_RST;
      max_backoff     <= MAX_BACKOFF_RST;
      network_count   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_INIT_BACKOFF: initial_backoff <= cfg_data[MS_W-1:0];
        CFG_MAX_BACKOFF:  max_backoff     <= cfg_data[MS_W-1:0];
        CFG_NET_COUNT:    network_count   <= cfg_data[NCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign nets = (network_count > NCOUNT_W'(NETWORKS)) ? NCOUNT_W'(NETWORKS) : network_count;

  // restoring remainder, one quotient bit per cycle
  assign dividend = (op_t'(op) == OP_LINK_LOST) ? DIV_W'(next_network) + DIV_W'(1)
                                                : DIV_W'(next_network);
  assign trial    = TRIAL_W'(nets) << step;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q       <= op;
      consumer_q <= consumer;
      rem        <= dividend;
      step       <= STEP_W'(DIV_W - 1);
    end else if (cmd.step) begin
      if (TRIAL_W'(rem) >= trial) begin
        rem <= rem - trial[DIV_W-1:0];
      end
      step <= step - STEP_W'(1);
    end
  end

  assign status.div_last = (step == '0);
  assign status.out_busy = res_valid && !res_ready;

  // event update
  assign bit_mask = (32'(consumer_q) < CONSUMERS) ? (CONSUMERS'(1) << consumer_q) : '0;
  assign held     = count_requests(request_bits);
  assign doubled  = {backoff_now, 1'b0};

  always_comb begin
    request_bits_next     = request_bits;
    link_mode_next        = link_mode;
    has_address_next      = has_address;
    backoff_now_next      = backoff_now;
    next_network_next     = next_network;
    attempts_seen_next    = attempts_seen;
    failures_seen_next    = failures_seen;
    disconnects_seen_next = disconnects_seen;
    do_attempt            = 1'b0;
    result                = '0;

    unique case (op_t'(op_q))
      OP_REQUEST: begin
        if ((bit_mask != '0) && ((request_bits & bit_mask) == '0)) begin
          request_bits_next = request_bits | bit_mask;
          if (held == '0) begin
            backoff_now_next   = initial_backoff;
            result.radio_start = 1'b1;
          end
        end
      end
      OP_RELEASE: begin
        if ((request_bits & bit_mask) != '0) begin
          request_bits_next = request_bits & ~bit_mask;
          if ((request_bits & ~bit_mask) == '0) begin
            has_address_next  = 1'b0;
            link_mode_next    = MODE_OFF;
            result.radio_stop = 1'b1;
          end
        end
      end
      OP_RADIO_UP: begin
        do_attempt = 1'b1;
      end
      OP_LINK_LOST: begin
        has_address_next = 1'b0;
        if (link_mode == MODE_CONNECTED) begin
          disconnects_seen_next = disconnects_seen + CNT_W'(1);
        end else begin
          failures_seen_next = failures_seen + CNT_W'(1);
        end
        if (held == '0) begin
          link_mode_next = MODE_OFF;
        end else begin
          result.wait_ms = backoff_now;
          if (backoff_now < max_backoff) begin
            backoff_now_next = (doubled > {1'b0, max_backoff}) ? max_backoff
                                                                : doubled[MS_W-1:0];
          end
          if (nets > NCOUNT_W'(1)) begin
            next_network_next = rem[NET_W-1:0];
          end
          do_attempt = 1'b1;
        end
      end
      OP_ADDR_OK: begin
        has_address_next = 1'b1;
        link_mode_next   = MODE_CONNECTED;
        backoff_now_next = initial_backoff;
      end
      default: ;
    endcase

    if (do_attempt) begin
      if (nets == '0) begin
        link_mode_next = MODE_NO_CONFIG;
      end else begin
        link_mode_next       = MODE_CONNECTING;
        attempts_seen_next   = attempts_seen + CNT_W'(1);
        result.connect_now   = 1'b1;
        result.network_index = rem[NET_W-1:0];
      end
    end

    // an idle link reads as no config while no networks are stored
    if ((link_mode_next == MODE_OFF) || (link_mode_next == MODE_NO_CONFIG)) begin
      result.link_state = (network_count == '0) ? MODE_NO_CONFIG : MODE_OFF;
    end else begin
      result.link_state = link_mode_next;
    end
    result.address_held     = has_address_next;
    result.active_consumers = count_requests(request_bits_next);
    result.attempt_count    = attempts_seen_next;
    result.failure_count    = failures_seen_next;
    result.disconnect_count = disconnects_seen_next;
    result.backoff_level_ms = backoff_now_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      request_bits     <= '0;
      link_mode        <= MODE_OFF;
      has_address      <= 1'b0;
      backoff_now      <= INIT_BACKOFF_RST;
      next_network     <= '0;
      attempts_seen    <= '0;
      failures_seen    <= '0;
      disconnects_seen <= '0;
      res_valid        <= 1'b0;
    end else if (cmd.commit) begin
      request_bits     <= request_bits_next;
      link_mode        <= link_mode_next;
      has_address      <= has_address_next;
      backoff_now      <= backoff_now_next;
      next_network     <= next_network_next;
      attempts_seen    <= attempts_seen_next;
      failures_seen    <= failures_seen_next;
      disconnects_seen <= disconnects_seen_next;
      res_valid        <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_data <= result;
    end
  end

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(res_valid && !res_ready))
    else $error("result committed over an untaken beat");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> res_valid)
    else $error("commit did not present a result");

  a_connect_state: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.connect_now) |-> (res_data.link_state == MODE_CONNECTING))
    else $error("connect command without connecting state");

  a_stop_empty: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.radio_stop) |-> (res_data.active_consumers == '0))
    else $error("radio stop while consumers remain");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && (nets != '0)) |-> (NCOUNT_W'(rem) < nets))
    else $error("remainder not below network count");

endmodule

// ===== rtl/link_reconnect_supervisor.sv =====
`timescale 1ns / 1ps
// top level of the link reconnect supervisor
//
// events (request, release, radio started, link lost, address obtained)
// arrive on the evt channel, one beat per event; each event gives exactly
// one beat on the res channel with the commands and a status snapshot.
// configuration (initial backoff, backoff ceiling, network count) is
// written through cfg_we / cfg_index / cfg_data; the user must write it
// only while no event is in work, as the block does not enforce it.
// an event goes from accept to the next accept through the capture of it,
// the remainder steps that pick the network index, and the commit of the
// state with the load of the result register. the result shows on the
// clock after the commit and stays until taken.
// a new event is accepted while a result still waits; its commit then holds
// until the pending beat has been taken, so a stalled receiver stops the
// block after one more event.
// synchronous reset returns link state, counters, controller state and
// configuration to reset values and drops res.valid.
module link_reconnect_supervisor import lrs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lrs_event_if.sink             evt,
  lrs_result_if.source          res
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  result_t    res_data;
  logic       res_valid;

  lrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt.valid),
    .evt_ready (evt.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lrs_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op        (evt.op),
    .consumer  (evt.consumer),
    .cmd       (cmd),
    .status    (status),
    .res_valid (res_valid),
    .res_ready (res.ready),
    .res_data  (res_data)
  );

  assign res.valid            = res_valid;
  assign res.link_state       = res_data.link_state;
  assign res.radio_start      = res_data.radio_start;
  assign res.radio_stop       = res_data.radio_stop;
  assign res.connect_now      = res_data.connect_now;
  assign res.network_index    = res_data.network_index;
  assign res.wait_ms          = res_data.wait_ms;
  assign res.address_held     = res_data.address_held;
  assign res.active_consumers = res_data.active_consumers;
  assign res.attempt_count    = res_data.attempt_count;
  assign res.failure_count    = res_data.failure_count;
  assign res.disconnect_count = res_data.disconnect_count;
  assign res.backoff_level_ms = res_data.backoff_level_ms;

endmodule
